// ===== rtl/sfc_pkg.sv =====
// Shared types, constants and the CRC-8 function for the sensor frame check filter.
// No dependencies; every module of the block imports this package.
package sfc_pkg;

	localparam logic [7:0]  CRC_INIT    = 8'hff;
	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [15:0] MIN_CHANGE_RESET = 16'd10;
	localparam logic [14:0] TEMP_SPAN   = 15'd17500;
	localparam logic [15:0] ROUND_HALF  = 16'd32767;
	localparam logic [16:0] RAW_FULL    = 17'd65535;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;
	localparam logic [13:0] HUM_SPAN    = 14'd10000;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_CRC    = 2'd1;
	localparam logic [1:0] ST_HOLD   = 2'd2;

	// queue entry: front classification plus raw words
	typedef struct packed {
		logic        crc_ok;
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
	} sfc_item_t;

	// filter decision handed to the scaling stages
	typedef struct packed {
		logic [1:0]        status;
		logic [15:0]       temp_raw;
		logic [15:0]       hum_raw;
		logic [31:0]       seq;
		logic signed [2:0] temp_trend;
		logic signed [2:0] hum_trend;
	} sfc_res_t;

	// CRC-8, MSB first, high byte then low byte, no final xor
	function automatic logic [7:0] crc8_word(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0]  c;
		logic [15:0] w;
		c = CRC_INIT;
		w = {hi, lo};
		for (int i = 15; i >= 0; i--) begin
			if (c[7] ^ w[i]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/sensor_frame_check_filter.sv =====
// Top level of the sensor frame check filter: front end, queue, filter back end, scaling.
// Depends on sfc_pkg, sfc_front, sfc_queue, sfc_back, sfc_scale.
//
// Usage:
//  - Input channel (in_valid / in_stall) carries one six-byte frame per beat.
//    A beat is taken when in_valid is high and in_stall is low.
//  - Output channel (out_valid / out_stall) gives one result per frame, in order.
//  - cfg_valid / cfg_ready writes min_change from cfg_data; cfg_ready is always
//    high. Write it only while no frame is in flight.
//  - Throughput is one frame per cycle while out_stall is low. From the input beat
//    to out_valid a frame passes: queue write at the beat, filter decision (s1),
//    constant multiply (s2), divide-by-65535 correction and output register (s3).
//  - The filter state is updated when a frame leaves the queue, so each frame
//    sees the state left by the one before it without added cycles.
//  - While out_stall holds a finished result in s3 the back stages freeze; the queue
//    (QDEPTH entries) keeps taking frames until it fills, then in_stall goes high.
//  - Reset clears references, trends and sequence count, sets min_change to 10
//    and empties the queue; the block is ready the cycle after reset.
module sensor_frame_check_filter import sfc_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         temp_high,
	input  logic [7:0]         temp_low,
	input  logic [7:0]         temp_check,
	input  logic [7:0]         hum_high,
	input  logic [7:0]         hum_low,
	input  logic [7:0]         hum_check,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        hum_centi,
	output logic [31:0]        seq_number,
	output logic signed [2:0]  temp_trend_out,
	output logic signed [2:0]  hum_trend_out
);

	sfc_item_t front_item;
	sfc_item_t head;
	sfc_res_t  res_s1;
	logic      push;
	logic      pop;
	logic      head_valid;
	logic      queue_full;
	logic      adv;
	logic      valid_s1;
	logic      cfg_write;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign in_stall  = queue_full;
	assign push      = in_valid && !in_stall;

	sfc_front u_front (
		.temp_high  (temp_high),
		.temp_low   (temp_low),
		.temp_check (temp_check),
		.hum_high   (hum_high),
		.hum_low    (hum_low),
		.hum_check  (hum_check),
		.item       (front_item)
	);

	sfc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.head      (head),
		.not_empty (head_valid),
		.full      (queue_full)
	);

	sfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_write),
		.cfg_data   (cfg_data),
		.head       (head),
		.head_valid (head_valid),
		.adv        (adv),
		.pop        (pop),
		.valid_s1   (valid_s1),
		.res_s1     (res_s1)
	);

	sfc_scale u_scale (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.res_s1         (res_s1),
		.adv            (adv),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.temp_centi     (temp_centi),
		.hum_centi      (hum_centi),
		.seq_number     (seq_number),
		.temp_trend_out (temp_trend_out),
		.hum_trend_out  (hum_trend_out)
	);

endmodule

// ===== rtl/sfc_front.sv =====
// Front end: checks both CRC bytes of an incoming frame and builds the queue entry.
// Depends on sfc_pkg.
module sfc_front import sfc_pkg::*; (
	input  logic [7:0] temp_high,
	input  logic [7:0] temp_low,
	input  logic [7:0] temp_check,
	input  logic [7:0] hum_high,
	input  logic [7:0] hum_low,
	input  logic [7:0] hum_check,
	output sfc_item_t  item
);

	logic temp_ok;
	logic hum_ok;

	assign temp_ok = (crc8_word(temp_high, temp_low) == temp_check);
	assign hum_ok  = (crc8_word(hum_high, hum_low) == hum_check);

	assign item.crc_ok   = temp_ok && hum_ok;
	assign item.temp_raw = {temp_high, temp_low};
	assign item.hum_raw  = {hum_high, hum_low};

endmodule

// ===== rtl/sfc_queue.sv =====
// Short register FIFO between the front end and the filter back end.
// Depends on sfc_pkg.
module sfc_queue import sfc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  sfc_item_t push_item,
	input  logic      pop,
	output sfc_item_t head,
	output logic      not_empty,
	output logic      full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sfc_item_t         entry_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop)
		else $error("push into full queue");

endmodule

// ===== rtl/sfc_back.sv =====
// Back end: debounce and trend filter, reference/trend/sequence state, threshold register.
// Depends on sfc_pkg; registers its decision into stage s1.
module sfc_back import sfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	input  sfc_item_t   head,
	input  logic        head_valid,
	input  logic        adv,
	output logic        pop,
	output logic        valid_s1,
	output sfc_res_t    res_s1
);

	logic [15:0]       min_change_q;
	logic [15:0]       ref_temp_q;
	logic [15:0]       ref_hum_q;
	logic signed [2:0] temp_trend_q;
	logic signed [2:0] hum_trend_q;
	logic [31:0]       seq_q;

	logic [15:0]       temp_dist;
	logic [15:0]       hum_dist;
	logic              too_small;
	logic              temp_up;
	logic              hum_up;
	logic              temp_agree;
	logic              hum_agree;
	logic              accept;
	logic              trend_step;
	logic [1:0]        status;
	logic [31:0]       seq_next;
	logic signed [2:0] temp_trend_next;
	logic signed [2:0] hum_trend_next;

	assign pop = head_valid && adv;

	always_comb begin
		temp_dist  = (head.temp_raw >= ref_temp_q) ? head.temp_raw - ref_temp_q
		                                           : ref_temp_q - head.temp_raw;
		hum_dist   = (head.hum_raw >= ref_hum_q) ? head.hum_raw - ref_hum_q
		                                         : ref_hum_q - head.hum_raw;
		too_small  = (temp_dist < min_change_q) || (hum_dist < min_change_q);
		temp_up    = (head.temp_raw > ref_temp_q);
		hum_up     = (head.hum_raw > ref_hum_q);
		temp_agree = temp_up ? (temp_trend_q > 3'sd1) : (temp_trend_q < -3'sd1);
		hum_agree  = hum_up ? (hum_trend_q > 3'sd1) : (hum_trend_q < -3'sd1);

		accept     = head.crc_ok && !too_small && (temp_agree || hum_agree);
		// trends move only when the CRC is good and the size test passes but neither direction agrees
		trend_step = head.crc_ok && !too_small && !temp_agree && !hum_agree;

		if (!head.crc_ok) begin
			status = ST_CRC;
		end else if (accept) begin
			status = ST_ACCEPT;
		end else begin
			status = ST_HOLD;
		end

		// sequence skips zero on wrap
		seq_next = (seq_q == '1) ? 32'd1 : seq_q + 32'd1;

		temp_trend_next = temp_trend_q;
		hum_trend_next  = hum_trend_q;
		if (trend_step) begin
			temp_trend_next = temp_up ? temp_trend_q + 3'sd1 : temp_trend_q - 3'sd1;
			hum_trend_next  = hum_up ? hum_trend_q + 3'sd1 : hum_trend_q - 3'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_change_q <= MIN_CHANGE_RESET;
			ref_temp_q   <= '0;
			ref_hum_q    <= '0;
			temp_trend_q <= '0;
			hum_trend_q  <= '0;
			seq_q        <= '0;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				min_change_q <= cfg_data;
			end
			if (adv) begin
				valid_s1 <= pop;
			end
			if (pop) begin
				temp_trend_q <= temp_trend_next;
				hum_trend_q  <= hum_trend_next;
				if (accept) begin
					ref_temp_q <= head.temp_raw;
					ref_hum_q  <= head.hum_raw;
					seq_q      <= seq_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s1.status     <= status;
			res_s1.temp_raw   <= head.temp_raw;
			res_s1.hum_raw    <= head.hum_raw;
			res_s1.seq        <= accept ? seq_next : seq_q;
			res_s1.temp_trend <= temp_trend_next;
			res_s1.hum_trend  <= hum_trend_next;
		end
	end

	a_trend_range: assert property (@(posedge clk) disable iff (!arst_n)
		temp_trend_q >= -3'sd2 && temp_trend_q <= 3'sd2
		&& hum_trend_q >= -3'sd2 && hum_trend_q <= 3'sd2)
		else $error("trend counter out of range");
	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pop && accept |=> seq_q != '0)
		else $error("sequence number zero after accept");
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !accept |=> $stable(ref_temp_q) && $stable(ref_hum_q) && $stable(seq_q))
		else $error("reference changed without accept");

endmodule

// ===== rtl/sfc_scale.sv =====
// Scaling stages: raw words to hundredths with rounding, then the output register.
// Depends on sfc_pkg; constant multiply in s2, divide-by-65535 correction in s3.
module sfc_scale import sfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  sfc_res_t           res_s1,
	output logic               adv,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [14:0] temp_centi,
	output logic [13:0]        hum_centi,
	output logic [31:0]        seq_number,
	output logic signed [2:0]  temp_trend_out,
	output logic signed [2:0]  hum_trend_out
);

	logic              valid_s2;
	logic [1:0]        status_s2;
	logic [30:0]       temp_prod_s2;
	logic [29:0]       hum_prod_s2;
	logic [31:0]       seq_s2;
	logic signed [2:0] temp_trend_s2;
	logic signed [2:0] hum_trend_s2;

	logic              valid_s3;
	logic [1:0]        status_s3;
	logic [14:0]       temp_centi_s3;
	logic [13:0]       hum_centi_s3;
	logic [31:0]       seq_s3;
	logic signed [2:0] temp_trend_s3;
	logic signed [2:0] hum_trend_s3;

	logic [14:0]       temp_q0;
	logic [16:0]       temp_r0;
	logic [14:0]       temp_quot;
	logic [13:0]       hum_q0;
	logic [16:0]       hum_r0;
	logic [13:0]       hum_quot;

	// whole back pipeline moves unless a finished result is stalled
	assign adv = !valid_s3 || !out_stall;

	// x / 65535: q0 = x >> 16 leaves remainder low16 + q0, below twice the divisor
	always_comb begin
		temp_q0   = temp_prod_s2[30:16];
		temp_r0   = {1'b0, temp_prod_s2[15:0]} + 17'(temp_q0);
		temp_quot = temp_q0 + 15'(temp_r0 >= RAW_FULL);
		hum_q0    = hum_prod_s2[29:16];
		hum_r0    = {1'b0, hum_prod_s2[15:0]} + 17'(hum_q0);
		hum_quot  = hum_q0 + 14'(hum_r0 >= RAW_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2     <= res_s1.status;
			temp_prod_s2  <= 31'(res_s1.temp_raw) * 31'(TEMP_SPAN) + 31'(ROUND_HALF);
			hum_prod_s2   <= 30'(res_s1.hum_raw) * 30'(HUM_SPAN) + 30'(ROUND_HALF);
			seq_s2        <= res_s1.seq;
			temp_trend_s2 <= res_s1.temp_trend;
			hum_trend_s2  <= res_s1.hum_trend;

			status_s3     <= status_s2;
			temp_centi_s3 <= (status_s2 == ST_ACCEPT) ? temp_quot - TEMP_OFFSET : '0;
			hum_centi_s3  <= (status_s2 == ST_ACCEPT) ? hum_quot : '0;
			seq_s3        <= seq_s2;
			temp_trend_s3 <= temp_trend_s2;
			hum_trend_s3  <= hum_trend_s2;
		end
	end

	assign out_valid      = valid_s3;
	assign status         = status_s3;
	assign temp_centi     = temp_centi_s3;
	assign hum_centi      = hum_centi_s3;
	assign seq_number     = seq_s3;
	assign temp_trend_out = temp_trend_s3;
	assign hum_trend_out  = hum_trend_s3;

	a_zero_unless_accept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && status_s3 != ST_ACCEPT |-> temp_centi_s3 == '0 && hum_centi_s3 == '0)
		else $error("scaled value on non-accepted frame");

endmodule
